// ===== design/triangle_plane_clipper_unit_defines.svh =====
// assertion macros shared by the triangle plane clipper
// no dependencies; taken in by the top level with an include
`ifndef TRIANGLE_PLANE_CLIPPER_UNIT_DEFINES_SVH
`define TRIANGLE_PLANE_CLIPPER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tpc check failed");

// next-cycle implication, checked out of reset
`define TPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tpc check failed");

`endif

// ===== design/tpc_pkg.sv =====
// shared constants and types for the triangle plane clipper
// no dependencies
package tpc_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int CFG_IDX_W = 3;
	localparam int NORMAL_Y_RESET = 65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PP_X = 3'd0,
		REG_PP_Y = 3'd1,
		REG_PP_Z = 3'd2,
		REG_N_X  = 3'd3,
		REG_N_Y  = 3'd4,
		REG_N_Z  = 3'd5
	} cfg_reg_t;

	// control that travels with each item: valid and count of inside vertices
	typedef struct packed {
		logic       valid;
		logic [1:0] n_in;
	} stage_ctl_t;

endpackage

// ===== design/tpc_ifs.sv =====
// valid/ready channel interfaces for triangle items in and out
// depends on tpc_pkg
interface tpc_in_if #(parameter int W = tpc_pkg::COORD_WIDTH_DEF);
	logic valid;
	logic ready;
	logic signed [W-1:0] a_x, a_y, a_z;
	logic signed [W-1:0] b_x, b_y, b_z;
	logic signed [W-1:0] c_x, c_y, c_z;
	modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input ready);
	modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready);
endinterface

interface tpc_out_if #(parameter int W = tpc_pkg::COORD_WIDTH_DEF);
	logic valid;
	logic ready;
	logic signed [W-1:0] out_a_x, out_a_y, out_a_z;
	logic signed [W-1:0] out_b_x, out_b_y, out_b_z;
	logic signed [W-1:0] out_c_x, out_c_y, out_c_z;
	logic last_of_run;
	modport source(output valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
		out_c_x, out_c_y, out_c_z, last_of_run, input ready);
	modport sink(input valid, out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
		out_c_x, out_c_y, out_c_z, last_of_run, output ready);
endinterface

// ===== design/tpc_front.sv =====
// front stages: plane distances of the three vertices and edge selection
// depends on tpc_pkg
module tpc_front #(
	parameter int W = tpc_pkg::COORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [W-1:0] vtx [3][3],
	input  logic signed [W-1:0] pp [3],
	input  logic signed [W-1:0] nn [3],
	output tpc_pkg::stage_ctl_t ctl_s4,
	output logic signed [W-1:0] p_s4 [3][3],
	output logic [2*W:0]        di_s4 [2],
	output logic [2*W+1:0]      den_s4 [2],
	output logic [W-1:0]        dmag_s4 [2][3],
	output logic                dneg_s4 [2][3],
	output logic signed [W-1:0] base_s4 [2][3]
);
	localparam int DW = 2 * W + 2;

	logic                valid_s1, valid_s2, valid_s3;
	logic signed [W-1:0] vtx_s1 [3][3];
	logic signed [W-1:0] vtx_s2 [3][3];
	logic signed [W-1:0] vtx_s3 [3][3];
	logic signed [W:0]   diff_s1 [3][3];
	logic signed [2*W:0] prod_s2 [3][3];
	logic signed [DW-1:0] dist_s3 [3];

	logic [2:0] in_mask;
	logic [1:0] nin, i0, i1;
	logic [1:0] e_in [2];
	logic [1:0] e_out [2];
	logic signed [W:0] edge_diff [2][3];
	logic [W:0]        edge_abs [2][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			ctl_s4   <= '0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			ctl_s4.valid <= valid_s3;
			ctl_s4.n_in  <= nin;
		end
	end

	// s1 offsets from plane point, s2 products, s3 distance sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					vtx_s1[i][k]  <= vtx[i][k];
					diff_s1[i][k] <= $signed({vtx[i][k][W-1], vtx[i][k]})
						- $signed({pp[k][W-1], pp[k]});
					vtx_s2[i][k]  <= vtx_s1[i][k];
					prod_s2[i][k] <= diff_s1[i][k] * nn[k];
					vtx_s3[i][k]  <= vtx_s2[i][k];
				end
				dist_s3[i] <= DW'(prod_s2[i][0]) + DW'(prod_s2[i][1]) + DW'(prod_s2[i][2]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) in_mask[i] = !dist_s3[i][DW-1];
		nin = 2'd0;
		i0 = 2'd0;
		i1 = 2'd1;
		e_in[0] = 2'd0;
		e_out[0] = 2'd0;
		e_in[1] = 2'd0;
		e_out[1] = 2'd0;
		case (in_mask)
			3'b001: begin
				nin = 2'd1; i0 = 2'd0;
				e_in[0] = 2'd0; e_out[0] = 2'd1; e_in[1] = 2'd0; e_out[1] = 2'd2;
			end
			3'b010: begin
				nin = 2'd1; i0 = 2'd1;
				e_in[0] = 2'd1; e_out[0] = 2'd0; e_in[1] = 2'd1; e_out[1] = 2'd2;
			end
			3'b100: begin
				nin = 2'd1; i0 = 2'd2;
				e_in[0] = 2'd2; e_out[0] = 2'd0; e_in[1] = 2'd2; e_out[1] = 2'd1;
			end
			3'b011: begin
				nin = 2'd2; i0 = 2'd0; i1 = 2'd1;
				e_in[0] = 2'd0; e_out[0] = 2'd2; e_in[1] = 2'd1; e_out[1] = 2'd2;
			end
			3'b101: begin
				nin = 2'd2; i0 = 2'd0; i1 = 2'd2;
				e_in[0] = 2'd0; e_out[0] = 2'd1; e_in[1] = 2'd2; e_out[1] = 2'd1;
			end
			3'b110: begin
				nin = 2'd2; i0 = 2'd1; i1 = 2'd2;
				e_in[0] = 2'd1; e_out[0] = 2'd0; e_in[1] = 2'd2; e_out[1] = 2'd0;
			end
			3'b111: nin = 2'd3;
			default: nin = 2'd0;
		endcase
		for (int e = 0; e < 2; e++) begin
			for (int k = 0; k < 3; k++) begin
				edge_diff[e][k] = $signed({vtx_s3[e_out[e]][k][W-1], vtx_s3[e_out[e]][k]})
					- $signed({vtx_s3[e_in[e]][k][W-1], vtx_s3[e_in[e]][k]});
				edge_abs[e][k] = edge_diff[e][k][W] ? (-edge_diff[e][k]) : edge_diff[e][k];
			end
		end
	end

	// s4 edge parameters for the two cuts
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				p_s4[0][k] <= vtx_s3[i0][k];
				p_s4[1][k] <= vtx_s3[i1][k];
				p_s4[2][k] <= vtx_s3[2][k];
			end
			for (int e = 0; e < 2; e++) begin
				di_s4[e]  <= dist_s3[e_in[e]][2*W:0];
				den_s4[e] <= dist_s3[e_in[e]] - dist_s3[e_out[e]];
				for (int k = 0; k < 3; k++) begin
					dmag_s4[e][k] <= edge_abs[e][k][W-1:0];
					dneg_s4[e][k] <= edge_diff[e][k][W];
					base_s4[e][k] <= vtx_s3[e_in[e]][k];
				end
			end
		end
	end

endmodule

// ===== design/tpc_cut.sv =====
// one coordinate of an edge cut: offset product, restoring divide, add
// depends on tpc_pkg
module tpc_cut #(
	parameter int W = tpc_pkg::COORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                en,
	input  logic [2*W:0]        di,
	input  logic [2*W+1:0]      den,
	input  logic [W-1:0]        dmag,
	input  logic                dneg,
	input  logic signed [W-1:0] base,
	output logic signed [W-1:0] res
);
	localparam int DW = 2 * W + 2;

	logic [2*W-1:0] plo_s1;
	logic [2*W:0]   phi_s1;
	logic [DW-1:0]  den_s1;
	logic           dneg_s1;
	logic [W-1:0]   base_s1;

	// divider stages: index 0 is the loaded partial remainder
	logic [DW-1:0] rem_s2 [W+1];
	logic [W-1:0]  quo_s2 [W+1];
	logic [W-1:0]  low_s2 [W+1];
	logic [DW-1:0] den_s2 [W+1];
	logic          dneg_s2 [W+1];
	logic [W-1:0]  base_s2 [W+1];

	logic [W:0] sum;

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1  <= di[W-1:0] * dmag;
			phi_s1  <= di[2*W:W] * dmag;
			den_s1  <= den;
			dneg_s1 <= dneg;
			base_s1 <= base;
			// quotient is below 2^W, so the top part starts below the divisor
			rem_s2[0]  <= {1'b0, phi_s1} + {{(W + 2){1'b0}}, plo_s1[2*W-1:W]};
			low_s2[0]  <= plo_s1[W-1:0];
			quo_s2[0]  <= '0;
			den_s2[0]  <= den_s1;
			dneg_s2[0] <= dneg_s1;
			base_s2[0] <= base_s1;
		end
	end

	for (genvar s = 0; s < W; s++) begin : g_div
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;
		assign trial = {rem_s2[s], low_s2[s][W-1]};
		assign ge    = trial >= {1'b0, den_s2[s]};
		assign diff  = trial - {1'b0, den_s2[s]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s2[s+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				quo_s2[s+1]  <= {quo_s2[s][W-2:0], ge};
				low_s2[s+1]  <= {low_s2[s][W-2:0], 1'b0};
				den_s2[s+1]  <= den_s2[s];
				dneg_s2[s+1] <= dneg_s2[s];
				base_s2[s+1] <= base_s2[s];
			end
		end
	end

	// the cut lies between the two vertices, so it always fits
	assign sum = dneg_s2[W] ? ({base_s2[W][W-1], base_s2[W]} - {1'b0, quo_s2[W]})
		: ({base_s2[W][W-1], base_s2[W]} + {1'b0, quo_s2[W]});

	always_ff @(posedge clk) begin
		if (en) res <= sum[W-1:0];
	end

endmodule

// ===== design/tpc_outbuf.sv =====
// result buffer: builds up to two triangles per item and sends them in order
// depends on tpc_pkg and tpc_out_if
module tpc_outbuf #(
	parameter int W = tpc_pkg::COORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [1:0]          n_in,
	input  logic signed [W-1:0] p [3][3],
	input  logic signed [W-1:0] c0 [3],
	input  logic signed [W-1:0] c1 [3],
	output logic                can_take,
	tpc_out_if.source           out_ch
);
	logic [1:0]          cnt_q;
	logic                last0_q;
	logic signed [W-1:0] tri0_q [3][3];
	logic signed [W-1:0] tri1_q [3][3];
	logic                pop;

	assign pop      = out_ch.valid && out_ch.ready;
	assign can_take = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			case (n_in)
				2'd0: cnt_q <= 2'd0;
				2'd2: cnt_q <= 2'd2;
				default: cnt_q <= 2'd1;
			endcase
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last0_q <= (n_in != 2'd2);
			tri0_q[0] <= p[0];
			case (n_in)
				2'd3: begin
					tri0_q[1] <= p[1];
					tri0_q[2] <= p[2];
				end
				2'd2: begin
					tri0_q[1] <= p[1];
					tri0_q[2] <= c0;
				end
				default: begin
					tri0_q[1] <= c0;
					tri0_q[2] <= c1;
				end
			endcase
			tri1_q[0] <= p[1];
			tri1_q[1] <= c0;
			tri1_q[2] <= c1;
		end else if (pop && cnt_q == 2'd2) begin
			last0_q <= 1'b1;
			tri0_q  <= tri1_q;
		end
	end

	assign out_ch.valid       = cnt_q != 2'd0;
	assign out_ch.last_of_run = last0_q;
	assign out_ch.out_a_x     = tri0_q[0][0];
	assign out_ch.out_a_y     = tri0_q[0][1];
	assign out_ch.out_a_z     = tri0_q[0][2];
	assign out_ch.out_b_x     = tri0_q[1][0];
	assign out_ch.out_b_y     = tri0_q[1][1];
	assign out_ch.out_b_z     = tri0_q[1][2];
	assign out_ch.out_c_x     = tri0_q[2][0];
	assign out_ch.out_c_y     = tri0_q[2][1];
	assign out_ch.out_c_z     = tri0_q[2][2];

endmodule

// ===== design/triangle_plane_clipper_unit.sv =====
// top level of the triangle plane clipper: config registers, pipeline, result buffer
// depends on tpc_pkg, tpc_ifs, tpc_front, tpc_cut, tpc_outbuf and the defines header
//
// Clips each incoming triangle against the plane set by a point and a normal
// (registers 0..5). A vertex is inside when dot(v - point, normal) >= 0, done
// exactly. Zero inside gives no item, three inside pass the triangle unchanged,
// one inside gives one triangle, two inside give two, the second carrying
// last_of_run. Cuts are exact, truncated toward the inside vertex. The pipeline
// takes a new triangle every cycle unless its last stage waits on the result
// buffer. Stages: four distance/select, one multiply, one remainder load, one
// divider stage per quotient bit, one add, one buffer. The single result channel
// sends one triangle per cycle while the sink is ready, so inputs that yield two
// triangles hold the input until the first is sent; sustained rate is one item
// per cycle for single results. Config writes must only happen with the pipeline
// drained.
`include "triangle_plane_clipper_unit_defines.svh"

module triangle_plane_clipper_unit #(
	parameter int COORD_WIDTH = tpc_pkg::COORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [COORD_WIDTH-1:0]       cfg_data,
	tpc_in_if.sink                       in_ch,
	tpc_out_if.source                    out_ch
);
	localparam int W = COORD_WIDTH;
	// multiply, remainder load, one stage per quotient bit, final add
	localparam int CUT_LAT = W + 3;

	logic signed [W-1:0] plane_point_q [3];
	logic signed [W-1:0] normal_q [3];

	logic signed [W-1:0] vtx [3][3];
	logic                en;
	logic                end_valid;
	logic                can_take;

	tpc_pkg::stage_ctl_t ctl_s4;
	logic signed [W-1:0] p_s4 [3][3];
	logic [2*W:0]        di_s4 [2];
	logic [2*W+1:0]      den_s4 [2];
	logic [W-1:0]        dmag_s4 [2][3];
	logic                dneg_s4 [2][3];
	logic signed [W-1:0] base_s4 [2][3];

	logic signed [W-1:0] cut_res [2][3];

	// item side data that rides alongside the cut units
	tpc_pkg::stage_ctl_t meta_ctl_s5 [CUT_LAT];
	logic signed [W-1:0] meta_p_s5 [CUT_LAT][3][3];

	// config registers, to be written only while drained; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_point_q[0] <= '0;
			plane_point_q[1] <= '0;
			plane_point_q[2] <= '0;
			normal_q[0]      <= '0;
			normal_q[1]      <= W'(tpc_pkg::NORMAL_Y_RESET);
			normal_q[2]      <= '0;
		end else if (cfg_we) begin
			case (tpc_pkg::cfg_reg_t'(cfg_idx))
				tpc_pkg::REG_PP_X: plane_point_q[0] <= cfg_data;
				tpc_pkg::REG_PP_Y: plane_point_q[1] <= cfg_data;
				tpc_pkg::REG_PP_Z: plane_point_q[2] <= cfg_data;
				tpc_pkg::REG_N_X:  normal_q[0]      <= cfg_data;
				tpc_pkg::REG_N_Y:  normal_q[1]      <= cfg_data;
				tpc_pkg::REG_N_Z:  normal_q[2]      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign vtx[0][0] = in_ch.a_x;
	assign vtx[0][1] = in_ch.a_y;
	assign vtx[0][2] = in_ch.a_z;
	assign vtx[1][0] = in_ch.b_x;
	assign vtx[1][1] = in_ch.b_y;
	assign vtx[1][2] = in_ch.b_z;
	assign vtx[2][0] = in_ch.c_x;
	assign vtx[2][1] = in_ch.c_y;
	assign vtx[2][2] = in_ch.c_z;

	// whole pipeline advances together; it holds only when the last stage
	// has an item the result buffer cannot take yet
	assign end_valid   = meta_ctl_s5[CUT_LAT-1].valid;
	assign en          = !end_valid || can_take;
	assign in_ch.ready = en;

	tpc_front #(.W(W)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_ch.valid),
		.vtx      (vtx),
		.pp       (plane_point_q),
		.nn       (normal_q),
		.ctl_s4   (ctl_s4),
		.p_s4     (p_s4),
		.di_s4    (di_s4),
		.den_s4   (den_s4),
		.dmag_s4  (dmag_s4),
		.dneg_s4  (dneg_s4),
		.base_s4  (base_s4)
	);

	// one cut unit per edge and coordinate
	for (genvar e = 0; e < 2; e++) begin : g_edge
		for (genvar k = 0; k < 3; k++) begin : g_coord
			tpc_cut #(.W(W)) u_cut (
				.clk  (clk),
				.en   (en),
				.di   (di_s4[e]),
				.den  (den_s4[e]),
				.dmag (dmag_s4[e][k]),
				.dneg (dneg_s4[e][k]),
				.base (base_s4[e][k]),
				.res  (cut_res[e][k])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < CUT_LAT; s++) meta_ctl_s5[s] <= '0;
		end else if (en) begin
			meta_ctl_s5[0] <= ctl_s4;
			for (int s = 1; s < CUT_LAT; s++) meta_ctl_s5[s] <= meta_ctl_s5[s-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_p_s5[0] <= p_s4;
			for (int s = 1; s < CUT_LAT; s++) meta_p_s5[s] <= meta_p_s5[s-1];
		end
	end

	tpc_outbuf #(.W(W)) u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (en && end_valid),
		.n_in     (meta_ctl_s5[CUT_LAT-1].n_in),
		.p        (meta_p_s5[CUT_LAT-1]),
		.c0       (cut_res[0]),
		.c1       (cut_res[1]),
		.can_take (can_take),
		.out_ch   (out_ch)
	);

	// a stalled input means a finished item is waiting behind a busy buffer
	`TPC_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ch.ready, end_valid && out_ch.valid)
	// the first of a split pair is always followed by its closing triangle
	`TPC_ASSERT_NEXT(a_pair_close, clk, arst_n,
		out_ch.valid && out_ch.ready && !out_ch.last_of_run,
		out_ch.valid && out_ch.last_of_run)
	// an empty buffer always takes the next item
	`TPC_ASSERT_NOW(a_empty_takes, clk, arst_n, !out_ch.valid, in_ch.ready)

endmodule
